// ===== src/mctb_pkg.sv =====
// Shared types and constants for the multi-channel timer bank.
// Used by multi_channel_timer_bank and the testbench; no dependencies.
package mctb_pkg;

  // Bank size and derived index width
  localparam int TIMERS = 8;
  localparam int IDX_W  = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  // Run-time counter wrap point and last count of a tick group
  localparam logic [30:0] RUN_WRAP  = 31'h7FFF_FFFF;
  localparam logic [3:0]  GROUP_END = 4'd9;

  // Request codes
  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_START_ONE  = 3'd1,
    REQ_START_AUTO = 3'd2,
    REQ_STOP       = 3'd3,
    REQ_CHECK      = 3'd4
  } req_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_CMD,
    ST_DONE
  } state_t;

  // One timer entry as stored in the memory
  typedef struct packed {
    logic [31:0] remaining;
    logic [31:0] reload;
    logic        flag;
    logic        auto_mode;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/mctb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module mctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/multi_channel_timer_bank.sv =====
// Top level of the multi-channel countdown timer bank.
// Depends on mctb_pkg and mctb_ram.
//
// The bank holds mctb_pkg::TIMERS countdown timers in one memory with a
// registered read. One transaction is worked on at a time: a tick sweeps
// every timer entry through a read-modify-write pipeline, one entry a
// cycle, as set by the single memory read port; start, stop and check read
// and rewrite one entry; an out-of-range id or an unknown request goes
// straight to the done state. A finished result sits in an output register,
// so the next transaction is accepted while it waits. No clearing pass is
// needed after reset: per-entry valid bits make unwritten timers read as
// zero.
module multi_channel_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_timer_id,
  input  logic [31:0] in_period,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_expired,
  output logic        out_bad_id,
  output logic [30:0] out_run_time,
  output logic        out_tenth_tick
);

  localparam int IW = mctb_pkg::IDX_W;

  mctb_pkg::state_t state_r, state_nxt;

  logic [2:0]           req_r;
  logic [IW-1:0]        idx_r;
  logic [31:0]          period_r;
  logic [IW-1:0]        sweep_idx_r;
  logic                 rd_valid_r;
  logic [mctb_pkg::TIMERS-1:0] valid_r;
  logic [30:0]          elapsed_r;
  logic [3:0]           group_r;
  logic                 res_expired_r;
  logic                 res_bad_r;
  logic                 res_tenth_r;
  logic                 out_valid_r;
  logic                 out_expired_r;
  logic                 out_bad_r;
  logic [30:0]          out_run_time_r;
  logic                 out_tenth_r;

  logic                 in_fire;
  logic                 in_range;
  logic                 is_tick;
  logic                 is_cmd;
  logic                 sweep_last;
  logic                 out_free;
  logic [30:0]          elapsed_inc;

  logic                 ram_wr_en;
  logic [IW-1:0]        ram_wr_addr;
  mctb_pkg::entry_t     ram_wr_data;
  logic                 ram_rd_en;
  logic [IW-1:0]        ram_rd_addr;
  logic [mctb_pkg::ENTRY_W-1:0] ram_rd_data;

  mctb_pkg::entry_t     entry_q;
  mctb_pkg::entry_t     tick_entry;
  mctb_pkg::entry_t     cmd_entry;
  logic [31:0]          rem_dec;

  // Decode the incoming transaction
  assign in_stall = (state_r != mctb_pkg::ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign in_range = ({1'b0, in_timer_id} < 9'(mctb_pkg::TIMERS));
  assign is_tick  = (in_req_type == mctb_pkg::REQ_TICK);
  assign is_cmd   = (in_req_type == mctb_pkg::REQ_START_ONE)
                 || (in_req_type == mctb_pkg::REQ_START_AUTO)
                 || (in_req_type == mctb_pkg::REQ_STOP)
                 || (in_req_type == mctb_pkg::REQ_CHECK);
  assign sweep_last = (sweep_idx_r == IW'(mctb_pkg::TIMERS - 1));
  assign out_free   = !out_valid_r || !out_stall;
  assign elapsed_inc = elapsed_r + 31'd1;

  // Entry read back; an entry never written reads as zero
  assign entry_q = rd_valid_r ? mctb_pkg::entry_t'(ram_rd_data) : '0;

  // Tick update of one entry
  assign rem_dec = entry_q.remaining - 32'd1;
  always_comb begin
    tick_entry = entry_q;
    if (entry_q.remaining != 32'd0) begin
      tick_entry.remaining = rem_dec;
      if (rem_dec == 32'd0) begin
        tick_entry.flag = 1'b1;
        if (entry_q.auto_mode) begin
          tick_entry.remaining = entry_q.reload;
        end
      end
    end
  end

  // Command update of one entry
  always_comb begin
    cmd_entry = entry_q;
    case (req_r)
      mctb_pkg::REQ_START_ONE, mctb_pkg::REQ_START_AUTO: begin
        cmd_entry.remaining = period_r;
        cmd_entry.reload    = period_r;
        cmd_entry.flag      = 1'b0;
        cmd_entry.auto_mode = (req_r == mctb_pkg::REQ_START_AUTO);
      end
      mctb_pkg::REQ_STOP: begin
        cmd_entry.remaining = 32'd0;
        cmd_entry.flag      = 1'b0;
        cmd_entry.auto_mode = 1'b0;
      end
      mctb_pkg::REQ_CHECK: begin
        cmd_entry.flag = 1'b0;
      end
      default: begin
        cmd_entry = entry_q;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mctb_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_tick) begin
            state_nxt = mctb_pkg::ST_TICK;
          end else if (is_cmd && in_range) begin
            state_nxt = mctb_pkg::ST_CMD;
          end else begin
            state_nxt = mctb_pkg::ST_DONE;
          end
        end
      end
      mctb_pkg::ST_TICK: begin
        if (sweep_last) begin
          state_nxt = mctb_pkg::ST_DONE;
        end
      end
      mctb_pkg::ST_CMD: begin
        state_nxt = mctb_pkg::ST_DONE;
      end
      mctb_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = mctb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mctb_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory port controls per state
  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = '0;
    ram_wr_en   = 1'b0;
    ram_wr_addr = '0;
    ram_wr_data = tick_entry;
    case (state_r)
      mctb_pkg::ST_IDLE: begin
        if (in_fire && is_tick) begin
          ram_rd_en = 1'b1;
        end else if (in_fire && is_cmd && in_range) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = in_timer_id[IW-1:0];
        end
      end
      mctb_pkg::ST_TICK: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = sweep_idx_r;
        ram_wr_data = tick_entry;
        ram_rd_en   = !sweep_last;
        ram_rd_addr = sweep_idx_r + IW'(1);
      end
      mctb_pkg::ST_CMD: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r;
        ram_wr_data = cmd_entry;
      end
      mctb_pkg::ST_DONE: begin
        ram_rd_en = 1'b0;
      end
      default: begin
        ram_rd_en = 1'b0;
      end
    endcase
  end

  // Timer state memory
  mctb_ram #(
    .WIDTH (mctb_pkg::ENTRY_W),
    .DEPTH (mctb_pkg::TIMERS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mctb_pkg::ST_IDLE;
      valid_r     <= '0;
      elapsed_r   <= '0;
      group_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // mark entries written
      if (ram_wr_en) begin
        valid_r[ram_wr_addr] <= 1'b1;
      end
      // advance run time and tick group on an accepted tick
      if (in_fire && is_tick) begin
        elapsed_r <= (elapsed_inc == mctb_pkg::RUN_WRAP) ? 31'd0 : elapsed_inc;
        group_r   <= (group_r == mctb_pkg::GROUP_END) ? 4'd0 : group_r + 4'd1;
      end
      // hold the result until taken
      if (state_r == mctb_pkg::ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r         <= in_req_type;
      idx_r         <= in_timer_id[IW-1:0];
      period_r      <= in_period;
      res_expired_r <= 1'b0;
      res_bad_r     <= !in_range && (in_req_type == mctb_pkg::REQ_START_ONE
                                  || in_req_type == mctb_pkg::REQ_START_AUTO
                                  || in_req_type == mctb_pkg::REQ_STOP);
      res_tenth_r   <= is_tick && (group_r == mctb_pkg::GROUP_END);
      sweep_idx_r   <= '0;
    end else if (state_r == mctb_pkg::ST_TICK) begin
      sweep_idx_r <= sweep_idx_r + IW'(1);
    end else if (state_r == mctb_pkg::ST_CMD) begin
      res_expired_r <= (req_r == mctb_pkg::REQ_CHECK) && entry_q.flag;
    end
    if (ram_rd_en) begin
      rd_valid_r <= valid_r[ram_rd_addr];
    end
    if (state_r == mctb_pkg::ST_DONE && out_free) begin
      out_expired_r  <= res_expired_r;
      out_bad_r      <= res_bad_r;
      out_run_time_r <= elapsed_r;
      out_tenth_r    <= res_tenth_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_expired    = out_expired_r;
  assign out_bad_id     = out_bad_r;
  assign out_run_time   = out_run_time_r;
  assign out_tenth_tick = out_tenth_r;

  // Sweep never writes the entry it is reading
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != ram_rd_addr))
    else $error("read and write hit the same timer entry");

  // Run time never reaches the wrap value
  a_run_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    elapsed_r != mctb_pkg::RUN_WRAP)
    else $error("run time reached wrap value");

  // Tick group counter stays within one group
  a_group_range: assert property (@(posedge clk) disable iff (!rst_n)
    group_r <= mctb_pkg::GROUP_END)
    else $error("tick group counter out of range");

  // A new result appears only out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mctb_pkg::ST_DONE))
    else $error("result raised outside done state");

  // A rejected id never reports an expiry
  a_bad_not_expired: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_bad_r && out_expired_r))
    else $error("bad id result reports expiry");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for multi_channel_timer_bank: directed and random timer requests.
// Depends on mctb_pkg and the timer bank RTL. A built-in predictor supplies expected results.
module testbench;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  id;
    logic [31:0] period;
  } request_t;

  typedef struct packed {
    logic        expired;
    logic        bad_id;
    logic [30:0] run_time;
    logic        tenth;
  } result_t;

  localparam int MAX_WAIT     = 18;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 4 * (mctb_pkg::TIMERS + 2);

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = mctb_pkg::REQ_TICK;
  logic [7:0]  in_timer_id = 8'd0;
  logic [31:0] in_period = 32'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_expired;
  logic        out_bad_id;
  logic [30:0] out_run_time;
  logic        out_tenth_tick;

  // Predicted timer bank state
  logic [31:0] timer_remaining [mctb_pkg::TIMERS];
  logic [31:0] timer_reload [mctb_pkg::TIMERS];
  logic        timer_flag [mctb_pkg::TIMERS];
  logic        timer_auto [mctb_pkg::TIMERS];
  logic [30:0] elapsed_ticks;
  logic [3:0]  tick_group;

  request_t request_queue[$];
  result_t  pending_results[$];
  int       fail_count = 0;
  int       result_count = 0;
  int       gap_left = 0;
  int       stall_left = 0;

  multi_channel_timer_bank dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_timer_id   (in_timer_id),
    .in_period     (in_period),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_expired   (out_expired),
    .out_bad_id    (out_bad_id),
    .out_run_time  (out_run_time),
    .out_tenth_tick(out_tenth_tick)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the predicted bank by one request and return its result
  function automatic result_t timer_bank_step(request_t r);
    result_t res;
    logic    in_range;
    res = '0;
    in_range = (r.id < mctb_pkg::TIMERS);
    case (r.req)
      mctb_pkg::REQ_TICK: begin
        for (int k = 0; k < mctb_pkg::TIMERS; k++) begin
          if (timer_remaining[k] != 32'd0) begin
            timer_remaining[k] = timer_remaining[k] - 32'd1;
            if (timer_remaining[k] == 32'd0) begin
              timer_flag[k] = 1'b1;
              if (timer_auto[k]) timer_remaining[k] = timer_reload[k];
            end
          end
        end
        elapsed_ticks = elapsed_ticks + 31'd1;
        if (elapsed_ticks == mctb_pkg::RUN_WRAP) elapsed_ticks = '0;
        if (tick_group == mctb_pkg::GROUP_END) begin
          tick_group = '0;
          res.tenth = 1'b1;
        end else begin
          tick_group = tick_group + 4'd1;
        end
      end
      mctb_pkg::REQ_START_ONE, mctb_pkg::REQ_START_AUTO: begin
        if (!in_range) begin
          res.bad_id = 1'b1;
        end else begin
          timer_remaining[r.id] = r.period;
          timer_reload[r.id] = r.period;
          timer_flag[r.id] = 1'b0;
          timer_auto[r.id] = (r.req == mctb_pkg::REQ_START_AUTO);
        end
      end
      mctb_pkg::REQ_STOP: begin
        if (!in_range) begin
          res.bad_id = 1'b1;
        end else begin
          timer_remaining[r.id] = '0;
          timer_flag[r.id] = 1'b0;
          timer_auto[r.id] = 1'b0;
        end
      end
      mctb_pkg::REQ_CHECK: begin
        if (in_range && timer_flag[r.id]) begin
          timer_flag[r.id] = 1'b0;
          res.expired = 1'b1;
        end
      end
      default: ;
    endcase
    res.run_time = elapsed_ticks;
    return res;
  endfunction

  task automatic queue_req(input logic [2:0] req, input logic [7:0] id,
                           input logic [31:0] period);
    request_t r;
    r.req = req;
    r.id = id;
    r.period = period;
    request_queue.push_back(r);
  endtask

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH result %0d %s: got %0h, want %0h", result_count, field, got, want);
    fail_count++;
  endtask

  // Draw how many cycles a side waits; about half the draws wait not at all
  function automatic int draw_wait();
    return $urandom_range(0, 1) ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Request driver: present queued transactions, predict each one as it is accepted
  always @(posedge clk) begin : request_driver
    request_t nxt;
    request_t seen;
    logic     presenting;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = draw_wait();
      for (int k = 0; k < mctb_pkg::TIMERS; k++) begin
        timer_remaining[k] = '0;
        timer_reload[k] = '0;
        timer_flag[k] = 1'b0;
        timer_auto[k] = 1'b0;
      end
      elapsed_ticks = '0;
      tick_group = '0;
    end else begin
      presenting = in_valid && in_stall;
      if (in_valid && !in_stall) begin
        seen.req = in_req_type;
        seen.id = in_timer_id;
        seen.period = in_period;
        pending_results.push_back(timer_bank_step(seen));
      end
      if (!presenting) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_queue.size() > 0) begin
          nxt = request_queue.pop_front();
          in_req_type <= nxt.req;
          in_timer_id <= nxt.id;
          in_period <= nxt.period;
          presenting = 1'b1;
          gap_left = draw_wait();
        end
      end
      in_valid <= presenting;
    end
  end

  // Result monitor: stall at random and compare each accepted transaction
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = draw_wait();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result",
                          {out_expired, out_bad_id, out_run_time[29:0]}, 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (out_expired !== want.expired)
            report_mismatch("expired", 32'(out_expired), 32'(want.expired));
          if (out_bad_id !== want.bad_id)
            report_mismatch("bad_id", 32'(out_bad_id), 32'(want.bad_id));
          if (out_run_time !== want.run_time)
            report_mismatch("run_time", 32'(out_run_time), 32'(want.run_time));
          if (out_tenth_tick !== want.tenth)
            report_mismatch("tenth_tick", 32'(out_tenth_tick), 32'(want.tenth));
        end
        result_count++;
        stall_left = draw_wait();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed cases, then random timer sequences mixed with noise
  initial begin : stimulus
    int target;
    int id;
    int n;
    logic [31:0] period;

    // One-shot expiry, then check twice
    queue_req(mctb_pkg::REQ_TICK, 8'd0, 32'd0);
    queue_req(mctb_pkg::REQ_START_ONE, 8'd0, 32'd1);
    queue_req(mctb_pkg::REQ_TICK, 8'd0, 32'd0);
    queue_req(mctb_pkg::REQ_CHECK, 8'd0, 32'd0);
    queue_req(mctb_pkg::REQ_CHECK, 8'd0, 32'd0);
    // Auto-reload on the last timer expires twice
    queue_req(mctb_pkg::REQ_START_AUTO, 8'(mctb_pkg::TIMERS - 1), 32'd2);
    repeat (4) queue_req(mctb_pkg::REQ_TICK, 8'hFF, 32'hFFFF_FFFF);
    queue_req(mctb_pkg::REQ_CHECK, 8'(mctb_pkg::TIMERS - 1), 32'd0);
    // Zero period never expires
    queue_req(mctb_pkg::REQ_START_ONE, 8'd3, 32'd0);
    queue_req(mctb_pkg::REQ_TICK, 8'd3, 32'd0);
    queue_req(mctb_pkg::REQ_CHECK, 8'd3, 32'd0);
    // Stop clears flag and mode
    queue_req(mctb_pkg::REQ_STOP, 8'(mctb_pkg::TIMERS - 1), 32'd0);
    queue_req(mctb_pkg::REQ_CHECK, 8'(mctb_pkg::TIMERS - 1), 32'd0);
    // Out-of-range ids
    queue_req(mctb_pkg::REQ_START_ONE, 8'(mctb_pkg::TIMERS), 32'd5);
    queue_req(mctb_pkg::REQ_START_AUTO, 8'hFF, 32'hFFFF_FFFF);
    queue_req(mctb_pkg::REQ_STOP, 8'd200, 32'd0);
    queue_req(mctb_pkg::REQ_CHECK, 8'hFF, 32'd0);
    // Unknown request codes
    for (int c = int'(mctb_pkg::REQ_CHECK) + 1; c < 8; c++)
      queue_req(3'(c), 8'd1, 32'hFFFF_FFFF);
    // Largest period, then stop
    queue_req(mctb_pkg::REQ_START_ONE, 8'd1, 32'hFFFF_FFFF);
    queue_req(mctb_pkg::REQ_TICK, 8'd0, 32'd0);
    queue_req(mctb_pkg::REQ_STOP, 8'd1, 32'd0);

    target = request_queue.size() + RANDOM_ITEMS;
    while (request_queue.size() < target) begin
      if ($urandom_range(0, 9) < 7) begin
        // Start a timer, tick it along, then check it
        id = $urandom_range(0, mctb_pkg::TIMERS - 1);
        queue_req($urandom_range(0, 1) ? mctb_pkg::REQ_START_AUTO : mctb_pkg::REQ_START_ONE,
                  8'(id), 32'($urandom_range(1, 12)));
        n = $urandom_range(0, 15);
        repeat (n) queue_req(mctb_pkg::REQ_TICK, 8'($urandom()), $urandom());
        queue_req(mctb_pkg::REQ_CHECK, 8'(id), $urandom());
        if ($urandom_range(0, 3) == 0) queue_req(mctb_pkg::REQ_STOP, 8'(id), $urandom());
      end else begin
        // Single noise transaction
        case ($urandom_range(0, 9))
          0:       period = '0;
          1:       period = 32'hFFFF_FFFF;
          2, 3:    period = $urandom();
          default: period = 32'($urandom_range(1, 12));
        endcase
        id = ($urandom_range(0, 5) == 0) ? $urandom_range(mctb_pkg::TIMERS, 255)
                                         : $urandom_range(0, mctb_pkg::TIMERS - 1);
        queue_req(3'($urandom_range(0, 7)), 8'(id), period);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait for all transactions and results, then a quiet period
    while (request_queue.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hold a hard limit on run length
  initial begin : watchdog
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/mctb_pkg.sv
src/mctb_ram.sv
src/multi_channel_timer_bank.sv
test/testbench.sv
